>>> design/tvdsl_pkg.sv
// Shared types and constants for the TVD slope limiter.
`default_nettype none
package tvdsl_pkg;

	// Limiter select codes.
	localparam logic [2:0] SEL_MINMOD    = 3'd0;
	localparam logic [2:0] SEL_MC        = 3'd1;
	localparam logic [2:0] SEL_VANLEER   = 3'd2;
	localparam logic [2:0] SEL_SUPERBEE  = 3'd3;
	localparam logic [2:0] SEL_VANALBADA = 3'd4;

	localparam int SEL_WIDTH = 3;

	typedef struct packed {
		logic neg;
		logic zero;
		logic use_div;
	} tvdsl_flags_t;

endpackage
`default_nettype wire

>>> design/tvd_slope_limiter.sv
// Top level of the TVD slope limiter: front stages, division cell chain and output stage.
// Stage 1, stage 2, a chain of SLOPE_WIDTH + 1 division cells, then the output register.
// Throughput: one pair per cycle while the pipeline is not stalled.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits and sets the limiter select to minmod.
// Data registers are not reset.
`default_nettype none
module tvd_slope_limiter
	import tvdsl_pkg::*;
#(
	parameter int SLOPE_WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [SEL_WIDTH-1:0]                  cfg_wr_data,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// Fields from bit 0: left_slope, right_slope.
	input  wire logic [((2*SLOPE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// Fields from bit 0: limited_slope.
	output logic      [((SLOPE_WIDTH+7)/8)*8-1:0]      m_axis_tdata
);

	localparam int W      = SLOPE_WIDTH;
	localparam int NC     = W + 1;
	localparam int RW     = 2 * W + 2;
	localparam int OUT_TW = ((W + 7) / 8) * 8;

	logic adv;
	logic [SEL_WIDTH-1:0] sel_q;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SEL_MINMOD;
		end else if (cfg_wr_en) begin
			sel_q <= cfg_wr_data;
		end
	end

	// Stage 1: magnitudes and signs.
	logic [W-1:0] a_in, b_in, x_c, y_c;
	logic         na, nb;
	logic [W-1:0] x_s1, y_s1;
	tvdsl_flags_t flags_s1;
	logic         v_s1;

	always_comb begin
		a_in = s_axis_tdata[W-1:0];
		b_in = s_axis_tdata[2*W-1:W];
		na   = a_in[W-1];
		nb   = b_in[W-1];
		x_c  = na ? (~a_in + 1'b1) : a_in;
		y_c  = nb ? (~b_in + 1'b1) : b_in;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1          <= x_c;
			y_s1          <= y_c;
			flags_s1.neg  <= na;
			flags_s1.zero <= (x_c == '0) || (y_c == '0) || (na != nb);
			flags_s1.use_div <= 1'b0;
		end
	end

	// Stage 2: products, simple limiters and divider operands.
	logic [2*W-1:0] xy, xx, yy;
	logic [W:0]     sum, mn, mx2a, mx2b, sb_a, sb_b, mag_c;
	logic [W+2:0]   four_x, four_y, sum_ext;
	logic [RW-1:0]  p_c, d_c;
	logic [W:0]     s_c;
	logic           div_c;

	always_comb begin
		xy      = {{W{1'b0}}, x_s1} * {{W{1'b0}}, y_s1};
		xx      = {{W{1'b0}}, x_s1} * {{W{1'b0}}, x_s1};
		yy      = {{W{1'b0}}, y_s1} * {{W{1'b0}}, y_s1};
		sum     = {1'b0, x_s1} + {1'b0, y_s1};
		mn      = (x_s1 < y_s1) ? {1'b0, x_s1} : {1'b0, y_s1};
		mx2a    = {x_s1, 1'b0};
		mx2b    = {y_s1, 1'b0};
		sb_a    = (mx2a < {1'b0, y_s1}) ? mx2a : {1'b0, y_s1};
		sb_b    = ({1'b0, x_s1} < mx2b) ? {1'b0, x_s1} : mx2b;
		four_x  = {1'b0, x_s1, 2'b00};
		four_y  = {1'b0, y_s1, 2'b00};
		sum_ext = {2'b00, sum};
		p_c     = '0;
		d_c     = RW'(1);
		s_c     = '0;
		div_c   = 1'b0;
		unique case (sel_q)
			SEL_MC: begin
				if (sum_ext < four_x && sum_ext < four_y) begin
					mag_c = {1'b0, sum[W:1]};
				end else begin
					mag_c = {mn[W-1:0], 1'b0};
				end
			end
			SEL_SUPERBEE: begin
				mag_c = (sb_a > sb_b) ? sb_a : sb_b;
			end
			SEL_VANLEER: begin
				mag_c = mn;
				div_c = 1'b1;
				p_c   = RW'(y_s1);
				d_c   = RW'(sum);
				s_c   = mx2a;
			end
			SEL_VANALBADA: begin
				mag_c = mn;
				div_c = 1'b1;
				p_c   = RW'(xy);
				d_c   = RW'(xx) + RW'(yy);
				s_c   = sum;
			end
			default: begin
				mag_c = mn;
			end
		endcase
	end

	logic [RW-1:0] p_s2, d_s2;
	logic [W:0]    s_s2, mag_s2;
	tvdsl_flags_t  flags_s2;
	logic          v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2             <= p_c;
			d_s2             <= d_c;
			s_s2             <= s_c;
			mag_s2           <= mag_c;
			flags_s2.neg     <= flags_s1.neg;
			flags_s2.zero    <= flags_s1.zero;
			flags_s2.use_div <= div_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
		end
	end

	// Division chain with the side data delayed alongside.
	logic [RW-1:0] r_c [NC+1];
	logic [W:0]    q_c [NC+1];
	logic [W:0]    s_ch [NC+1];
	logic [RW-1:0] p_ch [NC+1];
	logic [RW-1:0] d_ch [NC+1];
	logic [W:0]    mag_d [NC+1];
	tvdsl_flags_t  flags_d [NC+1];
	logic          v_d [NC+1];

	assign r_c[0]     = '0;
	assign q_c[0]     = '0;
	assign s_ch[0]    = s_s2;
	assign p_ch[0]    = p_s2;
	assign d_ch[0]    = d_s2;
	assign mag_d[0]   = mag_s2;
	assign flags_d[0] = flags_s2;
	assign v_d[0]     = v_s2;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		tvdsl_div_cell #(.W(W)) u_cell (
			.clk   (clk),
			.en    (adv),
			.r_in  (r_c[k]),
			.q_in  (q_c[k]),
			.s_in  (s_ch[k]),
			.p_in  (p_ch[k]),
			.d_in  (d_ch[k]),
			.r_out (r_c[k+1]),
			.q_out (q_c[k+1]),
			.s_out (s_ch[k+1]),
			.p_out (p_ch[k+1]),
			.d_out (d_ch[k+1])
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				mag_d[k+1]   <= mag_d[k];
				flags_d[k+1] <= flags_d[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (adv) begin
				v_d[k+1] <= v_d[k];
			end
		end
	end

	// Output stage: pick the magnitude, saturate, apply the sign and force zero cases to zero.
	localparam logic [W:0] TOP_MAG = (W+1)'(1) << (W - 1);

	logic [W:0]   mag_f, mag_sat;
	logic [W-1:0] res_c;
	tvdsl_flags_t fl_f;
	logic [W-1:0] out_q;
	logic         out_v_q;
	logic         out_zero_q;
	logic         out_neg_q;

	always_comb begin
		fl_f  = flags_d[NC];
		mag_f = fl_f.use_div ? q_c[NC] : mag_d[NC];
		if (fl_f.neg) begin
			mag_sat = (mag_f > TOP_MAG) ? TOP_MAG : mag_f;
			res_c   = ~mag_sat[W-1:0] + 1'b1;
		end else begin
			mag_sat = (mag_f > TOP_MAG - 1'b1) ? (TOP_MAG - 1'b1) : mag_f;
			res_c   = mag_sat[W-1:0];
		end
		if (fl_f.zero) begin
			res_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q      <= res_c;
			out_zero_q <= fl_f.zero;
			out_neg_q  <= fl_f.neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_d[NC];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OUT_TW'(out_q);

	// A zero or opposite-sign pair must give zero.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_zero_q) |-> (out_q == '0))
		else $error("zero case produced nonzero slope");

	// A positive result never has its sign bit set.
	a_pos_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_zero_q && !out_neg_q) |-> !out_q[W-1])
		else $error("positive result has sign bit set");

	// A negative nonzero result always has its sign bit set.
	a_neg_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_zero_q && out_neg_q && out_q != '0) |-> out_q[W-1])
		else $error("negative result lost its sign");

	// The output only becomes valid from an item leaving the last cell.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_d[NC]))
		else $error("output valid without an item in the last cell");

endmodule
`default_nettype wire

>>> design/tvdsl_div_cell.sv
// One cell of the division chain: takes one bit of the multiplier s and forms one quotient step.
`default_nettype none
module tvdsl_div_cell
	import tvdsl_pkg::*;
#(
	parameter int W = 32
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [2*W+1:0]  r_in,
	input  wire logic [W:0]      q_in,
	input  wire logic [W:0]      s_in,
	input  wire logic [2*W+1:0]  p_in,
	input  wire logic [2*W+1:0]  d_in,
	output logic      [2*W+1:0]  r_out,
	output logic      [W:0]      q_out,
	output logic      [W:0]      s_out,
	output logic      [2*W+1:0]  p_out,
	output logic      [2*W+1:0]  d_out
);

	localparam int RW = 2 * W + 2;

	logic [RW-1:0] t1, u1, t2, u2;
	logic          ge1, ge2;
	logic [W:0]    q_next;

	// The remainder stays below d, so doubling it and adding p < d needs at most
	// one subtraction after each of the two steps.
	always_comb begin
		t1     = {r_in[RW-2:0], 1'b0};
		ge1    = (t1 >= d_in);
		u1     = ge1 ? (t1 - d_in) : t1;
		t2     = u1 + (s_in[W] ? p_in : {RW{1'b0}});
		ge2    = (t2 >= d_in);
		u2     = ge2 ? (t2 - d_in) : t2;
		q_next = {q_in[W-1:0], 1'b0} + (W+1)'(ge1) + (W+1)'(ge2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_out <= u2;
			q_out <= q_next;
			s_out <= {s_in[W-1:0], 1'b0};
			p_out <= p_in;
			d_out <= d_in;
		end
	end

endmodule
`default_nettype wire

>>> sim/tvd_slope_limiter_checker.sv
// Checker for the TVD slope limiter: predicts each limited slope and compares the output stream.
`default_nettype none
module tvd_slope_limiter_checker
	import tvdsl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [SEL_WIDTH-1:0] cfg_wr_data,
	input  wire logic                 s_axis_tvalid,
	input  wire logic                 s_axis_tready,
	input  wire logic [63:0]          s_axis_tdata,
	input  wire logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	input  wire logic [31:0]          m_axis_tdata,
	output int                        failures,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [SEL_WIDTH-1:0] limiter_mode;
	logic [31:0] expected_slopes[$];

	function automatic logic [31:0] limit_slope(logic [2:0] sel, logic [31:0] a, logic [31:0] b);
		logic na, nb;
		logic [31:0] ta, tb;
		logic [127:0] x, y, mag;
		na = a[31];
		nb = b[31];
		ta = na ? -a : a;
		tb = nb ? -b : b;
		x = 128'(ta);
		y = 128'(tb);
		if (x == 0 || y == 0 || na != nb)
			return 32'd0;
		case (sel)
			SEL_MC: begin
				if (x + y < 4 * x && x + y < 4 * y)
					mag = (x + y) >> 1;
				else
					mag = 2 * ((x < y) ? x : y);
			end
			SEL_VANLEER: mag = (2 * x * y) / (x + y);
			SEL_SUPERBEE: begin
				logic [127:0] p, q;
				p = (2 * x < y) ? 2 * x : y;
				q = (x < 2 * y) ? x : 2 * y;
				mag = (p > q) ? p : q;
			end
			SEL_VANALBADA: mag = (x * y * (x + y)) / (x * x + y * y);
			default: mag = (x < y) ? x : y;
		endcase
		// Negative results may reach one step further than positive ones.
		if (na) begin
			if (mag > 128'h8000_0000)
				mag = 128'h8000_0000;
			return 32'(128'd0 - mag);
		end
		if (mag > 128'h7FFF_FFFF)
			mag = 128'h7FFF_FFFF;
		return 32'(mag);
	endfunction

	assign pending = expected_slopes.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limiter_mode <= SEL_MINMOD;
			failures = 0;
		end else begin
			if (cfg_wr_en)
				limiter_mode <= cfg_wr_data;
			if (s_axis_tvalid && s_axis_tready)
				expected_slopes.push_back(limit_slope(limiter_mode, s_axis_tdata[31:0],
					s_axis_tdata[63:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_slopes.size() == 0) begin
					$error("limited_slope: unexpected transfer, actual %0d",
						$signed(m_axis_tdata));
					failures++;
				end else begin
					logic [31:0] want;
					want = expected_slopes.pop_front();
					if (want !== m_axis_tdata) begin
						$error("limited_slope: expected %0d, actual %0d",
							$signed(want), $signed(m_axis_tdata));
						failures++;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> sim/tb_tvd_slope_limiter.sv
// Testbench top for the TVD slope limiter: stimulus, backpressure and verdict.
`default_nettype none
module tb_tvd_slope_limiter;
	import tvdsl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 37;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [SEL_WIDTH-1:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	int failures, pending;
	logic calm = 1'b0;
	logic hold_go = 1'b0;
	int hold_left = HOLD_CYCLES;
	int stall_cycles = 0;
	int sent = 0;

	always #10 clk = ~clk;

	tvd_slope_limiter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	tvd_slope_limiter_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.failures(failures), .pending(pending)
	);

	// Receiver: random stalls, one long hold-off on request.
	always @(negedge clk) begin
		if (hold_go && hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else
			m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (!s_axis_tvalid && pending == 0))
			stall_cycles = 0;
		else if (++stall_cycles >= STALL_LIMIT) begin
			$display("tvd_slope_limiter test failed");
			$finish;
		end
	end

	task automatic send_pair(logic [31:0] a, logic [31:0] b);
		while (!calm && $urandom_range(99) < 21) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, a};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		@(negedge clk);
	endtask

	task automatic set_limiter(logic [SEL_WIDTH-1:0] sel);
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= sel;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] random_slope(logic neg);
		logic [31:0] mag;
		case ($urandom_range(3))
			0: mag = $urandom_range(16);
			1: mag = $urandom_range(32'h0003_FFFF);
			2: mag = $urandom() >> $urandom_range(31);
			default: mag = $urandom();
		endcase
		mag[31] = 1'b0;
		if (mag == 0)
			mag = 1;
		if (neg && $urandom_range(15) == 0)
			return 32'h8000_0000;
		if (!neg && $urandom_range(15) == 0)
			return 32'h7FFF_FFFF;
		return neg ? -mag : mag;
	endfunction

	logic [31:0] corner_a[12] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
		32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0003_0000,
		32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0001};
	logic [31:0] corner_b[12] = '{32'h0005_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h0000_0000, 32'h0002_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0001_0000,
		32'h8000_0000, 32'h0001_0000, 32'h8000_0000};

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed corners under the reset selection first, then under every code.
		for (int sel = 0; sel < 8; sel++) begin
			if (sel != 0)
				set_limiter(SEL_WIDTH'(sel));
			for (int i = 0; i < 12; i++)
				send_pair(corner_a[i], corner_b[i]);
		end
		for (int phase = 0; phase < 10; phase++) begin
			set_limiter(phase < 8 ? SEL_WIDTH'(7 - phase) : SEL_WIDTH'($urandom_range(7)));
			calm <= (phase == 3);
			if (phase == 5)
				hold_go <= 1'b1;
			for (int i = 0; i < 185; i++) begin
				logic neg;
				neg = $urandom_range(1);
				if ($urandom_range(99) < 80)
					send_pair(random_slope(neg), random_slope(neg));
				else
					send_pair($urandom(), ($urandom_range(3) == 0) ? 32'h0 : $urandom());
			end
		end
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		$display("Sent %0d slope pairs across all eight limiter codes, with random stalls,", sent);
		$display("a gap-free stretch and one long output hold-off.");
		if (failures == 0)
			$display("tvd_slope_limiter test passed");
		else
			$display("tvd_slope_limiter test failed");
		$finish;
	end
endmodule
`default_nettype wire

>>> tvd_slope_limiter.f
design/tvdsl_pkg.sv
design/tvdsl_div_cell.sv
design/tvd_slope_limiter.sv
sim/tvd_slope_limiter_checker.sv
sim/tb_tvd_slope_limiter.sv
